FILE: hdl/hnht_pkg.sv
// Shared constants, codes and types for the hashed next hop table.
package hnht_pkg;

    localparam int DEF_SLOTS = 16;
    localparam int DEF_WAYS = 4;

    localparam int NODE_W = 8;
    localparam int NODE_COUNT = 1 << NODE_W;
    localparam int ENTRY_W = 2 * NODE_W;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    localparam logic [1:0] ST_UPDATED = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_LOOKUP = 2'd3;

    typedef struct packed {
        logic              wr_en;
        logic              grow;
        logic [1:0]        status;
        logic              found;
        logic [NODE_W-1:0] hop;
    } t_chain_res;

endpackage

FILE: hdl/hnht_row_mem.sv
// Slot row memory: one write port, one read port with registered read data.
module hnht_row_mem #(
    parameter int DEPTH = hnht_pkg::DEF_SLOTS,
    parameter int WIDTH = hnht_pkg::DEF_WAYS * hnht_pkg::ENTRY_W,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/hnht_chain_logic.sv
// Chain search and row update for one set or get request.
module hnht_chain_logic #(
    parameter int WAYS = hnht_pkg::DEF_WAYS,
    localparam int CW = $clog2(WAYS + 1),
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int RW = WAYS * hnht_pkg::ENTRY_W
) (
    input  logic                        i_cmd,
    input  logic [hnht_pkg::NODE_W-1:0] i_dest,
    input  logic [hnht_pkg::NODE_W-1:0] i_hop,
    input  logic [CW-1:0]               i_fill,
    input  logic [RW-1:0]               i_row,
    output logic [RW-1:0]               o_row,
    output hnht_pkg::t_chain_res        o_res
);

    localparam int EW = hnht_pkg::ENTRY_W;
    localparam int NW = hnht_pkg::NODE_W;

    logic          hit;
    logic [WW-1:0] hit_idx;
    logic [WW-1:0] free_idx;

    assign free_idx = i_fill[WW-1:0];

    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((CW'(w) < i_fill) && (i_row[w * EW + NW +: NW] == i_dest)) begin
                hit = 1'b1;
                hit_idx = WW'(w);
            end
        end
    end

    always_comb begin
        o_row = i_row;
        o_res = '0;
        if (i_cmd == hnht_pkg::CMD_GET) begin
            o_res.status = hnht_pkg::ST_LOOKUP;
            o_res.found = hit;
            o_res.hop = hit ? i_row[hit_idx * EW +: NW] : '0;
        end else if (hit) begin
            o_row[hit_idx * EW +: NW] = i_hop;
            o_res.wr_en = 1'b1;
            o_res.status = hnht_pkg::ST_UPDATED;
        end else if (i_fill < CW'(WAYS)) begin
            o_row[free_idx * EW +: EW] = {i_dest, i_hop};
            o_res.wr_en = 1'b1;
            o_res.grow = 1'b1;
            o_res.status = hnht_pkg::ST_INSERTED;
        end else begin
            o_res.status = hnht_pkg::ST_FULL;
        end
    end

endmodule

FILE: hdl/hashed_next_hop_table_unit.sv
// Top level of the hashed next hop table: request control, fill counts, result register.
//
// Input channel: i_valid, o_stall with i_command, i_dest_node, i_next_hop.
// Command set stores a next hop for a destination; command get looks it up.
// Output channel: o_valid, i_stall with o_status, o_found, o_hop_out; one
// result word per request, in request order.
// The destination picks slot dest_node mod SLOTS; each slot is one memory row
// of WAYS entries, filled in order, with a per-slot fill count in flip-flops.
// A taken request reads its row into the registered read data of the row memory;
// in the busy state its result is registered together with the row write-back.
// No new request is taken until the last one is done: the row is read and then
// written back through the single read and single write port of the row memory.
// The input is stalled while a request is in flight, and while a finished
// result still waits in the output register under i_stall.
// Reset clears all fill counts, empties the output register and leaves the
// block ready; no clearing pass over the row memory is needed.
module hashed_next_hop_table_unit #(
    parameter int SLOTS = hnht_pkg::DEF_SLOTS,
    parameter int WAYS = hnht_pkg::DEF_WAYS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic [hnht_pkg::NODE_W-1:0] i_dest_node,
    input  logic [hnht_pkg::NODE_W-1:0] i_next_hop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic                        o_found,
    output logic [hnht_pkg::NODE_W-1:0] o_hop_out
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(WAYS + 1);
    localparam int RW = WAYS * hnht_pkg::ENTRY_W;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    t_state                        r_state;
    logic                          r_cmd;
    logic [hnht_pkg::NODE_W-1:0]   r_dest;
    logic [hnht_pkg::NODE_W-1:0]   r_hop;
    logic [SW-1:0]                 r_slot;
    logic [CW-1:0]                 r_fill [SLOTS];
    logic                          r_out_vld;
    logic [1:0]                    r_status;
    logic                          r_found;
    logic [hnht_pkg::NODE_W-1:0]   r_hop_out;

    logic [SW-1:0]                 slot_lut [hnht_pkg::NODE_COUNT];
    logic                          accept;
    logic [SW-1:0]                 n_slot;
    logic [RW-1:0]                 rd_row;
    logic [RW-1:0]                 wr_row;
    hnht_pkg::t_chain_res          res;
    logic                          busy;

    for (genvar d = 0; d < hnht_pkg::NODE_COUNT; d++) begin : g_slot
        localparam int SlotD = d % SLOTS;
        assign slot_lut[d] = SW'(SlotD);
    end

    assign o_stall = (r_state != S_IDLE) || (r_out_vld && i_stall);
    assign accept = i_valid && !o_stall;
    assign n_slot = slot_lut[i_dest_node];
    assign busy = (r_state == S_BUSY);

    hnht_row_mem #(
        .DEPTH (SLOTS),
        .WIDTH (RW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (busy && res.wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (wr_row),
        .i_rd_en   (accept),
        .i_rd_addr (n_slot),
        .o_rd_data (rd_row)
    );

    hnht_chain_logic #(
        .WAYS (WAYS)
    ) u_chain_logic (
        .i_cmd  (r_cmd),
        .i_dest (r_dest),
        .i_hop  (r_hop),
        .i_fill (r_fill[r_slot]),
        .i_row  (rd_row),
        .o_row  (wr_row),
        .o_res  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_vld <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_fill[s] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (busy) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (busy && res.grow) begin
                r_fill[r_slot] <= r_fill[r_slot] + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_dest <= i_dest_node;
            r_hop <= i_next_hop;
            r_slot <= n_slot;
        end
        if (busy) begin
            r_status <= res.status;
            r_found <= res.found;
            r_hop_out <= res.hop;
        end
    end

    assign o_valid = r_out_vld;
    assign o_status = r_status;
    assign o_found = r_found;
    assign o_hop_out = r_hop_out;

`ifndef SYNTHESIS
    a_accept_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !r_out_vld))
        else $error("output register occupied while a request is in flight");

    a_busy_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (r_out_vld && (r_state == S_IDLE)))
        else $error("request finished without a result word");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_fill[r_slot] <= CW'(WAYS)))
        else $error("chain fill count beyond way count");

    a_get_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (r_cmd == hnht_pkg::CMD_GET)) |=> (r_status == hnht_pkg::ST_LOOKUP))
        else $error("lookup gave a set status");

    a_found_on_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_found) |-> (r_status == hnht_pkg::ST_LOOKUP))
        else $error("found flag on a set result");
`endif

endmodule
